// File: src/ising_lattice_metropolis_assert.svh
// Assertion macros for the Ising lattice block and its checker.
// Needs signals named clk and arst_n in the scope of each use.
`ifndef ISING_LATTICE_METROPOLIS_ASSERT_SVH
`define ISING_LATTICE_METROPOLIS_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ILM_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ilm check failed");

// Next-cycle implication, disabled while reset is held.
`define ILM_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ilm check failed");

`endif

// File: src/ilm_pkg.sv
// Shared types and constants of the Ising lattice Metropolis block.
// No dependencies; used by the lattice memory, the top level and the checker.
`timescale 1ns / 1ps

package ilm_pkg;

	localparam int DEFAULT_MAX_SIDE = 128;

	// Field widths
	localparam int COORD_W    = 7;
	localparam int SIDE_CFG_W = 8;
	localparam int THRESH_W   = 16;
	localparam int UNIFORM_W  = 16;
	localparam int DELTA_W    = 5;
	localparam int ENERGY_W   = 17;
	localparam int MAG_W      = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SIDE         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_FOUR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_EIGHT = 2'd2;

	// Action codes
	localparam logic ACT_FLIP = 1'b1;

	// Lattice memory control
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} mem_ctrl_t;

endpackage

// File: src/ilm_lattice_mem.sv
// Row-organized lattice store: one row of spins per entry, one read and one write port.
// Depends on ilm_pkg (mem_ctrl_t).
`timescale 1ns / 1ps

module ilm_lattice_mem #(
	parameter int MAX_SIDE = ilm_pkg::DEFAULT_MAX_SIDE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ilm_pkg::mem_ctrl_t          ctrl,
	input  logic [$clog2(MAX_SIDE)-1:0] rd_addr,
	input  logic [$clog2(MAX_SIDE)-1:0] wr_addr,
	input  logic [MAX_SIDE-1:0]         wr_row,
	output logic [MAX_SIDE-1:0]         rd_row
);

	logic [MAX_SIDE-1:0] mem [MAX_SIDE];
	logic [MAX_SIDE-1:0] row_valid_q;
	logic [MAX_SIDE-1:0] rd_data_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// A row never written since the last clear reads as all spins up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				row_valid_q <= '0;
			end else if (ctrl.wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_row = rd_data_q & {MAX_SIDE{rd_valid_q}};

endmodule

// File: src/ising_lattice_metropolis.sv
// Top level of the 2D Ising lattice with Metropolis single-spin updates.
// Depends on ilm_pkg and ilm_lattice_mem.
`timescale 1ns / 1ps

//  channel | signals                                             | dir | beat
//  --------+-----------------------------------------------------+-----+---------------------
//  in      | in_valid/in_ready, action row col spin_down uniform | in  | one spin write or flip
//  out     | out_valid/out_ready, flipped coord_error            | out | one result per item
//          |   energy_change total_energy total_magnetization    |     |
//  cfg     | cfg_write, cfg_index, cfg_data                      | in  | one register write
//
//  An in-range item goes from the accept cycle through three row reads (center, up, down)
//  through the single read port of the lattice memory, then the evaluate cycle, which writes
//  the row back when the spin changes. A coordinate error goes from accept straight to evaluate.
//  One item is in flight at a time; the output register lets the next item in while a
//  result still waits, and the evaluate cycle holds while that register is full and
//  out_ready is low. Reset is immediate: per-row valid bits make every row read as all up,
//  no clearing pass. Writing the side register clears those valid bits as well.

module ising_lattice_metropolis #(
	parameter int MAX_SIDE = ilm_pkg::DEFAULT_MAX_SIDE
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config
	input  logic                                  cfg_write,
	input  logic [ilm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ilm_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [ilm_pkg::COORD_W-1:0]           row,
	input  logic [ilm_pkg::COORD_W-1:0]           col,
	input  logic                                  spin_down,
	input  logic [ilm_pkg::UNIFORM_W-1:0]         uniform,
	// results
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  flipped,
	output logic                                  coord_error,
	output logic signed [ilm_pkg::DELTA_W-1:0]    energy_change,
	output logic signed [ilm_pkg::ENERGY_W-1:0]   total_energy,
	output logic signed [ilm_pkg::MAG_W-1:0]      total_magnetization
);

	localparam int ROW_W   = $clog2(MAX_SIDE);
	localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
	localparam int CMP_W   = (SIDE_W > ilm_pkg::COORD_W) ? SIDE_W : ilm_pkg::COORD_W;
	localparam int CLAMP_W = (SIDE_W > ilm_pkg::SIDE_CFG_W) ? SIDE_W : ilm_pkg::SIDE_CFG_W;
	localparam int SQ_W    = 2 * SIDE_W;
	localparam int RESET_SIDE = (MAX_SIDE < 128) ? MAX_SIDE : 128;

	localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'(RESET_SIDE);
	localparam logic [ilm_pkg::ENERGY_W-1:0] ENERGY_RST =
		ilm_pkg::ENERGY_W'(-2 * RESET_SIDE * RESET_SIDE);
	localparam logic [ilm_pkg::MAG_W-1:0] MAG_RST = ilm_pkg::MAG_W'(RESET_SIDE * RESET_SIDE);
	localparam logic [CLAMP_W-1:0] CLAMP_MIN = CLAMP_W'(2);
	localparam logic [CLAMP_W-1:0] CLAMP_MAX = CLAMP_W'(MAX_SIDE);
	localparam logic signed [ilm_pkg::DELTA_W-1:0] DELTA_FOUR  = ilm_pkg::DELTA_W'(4);
	localparam logic signed [ilm_pkg::DELTA_W-1:0] DELTA_EIGHT = ilm_pkg::DELTA_W'(8);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD_C = 5'b00010,
		S_RD_U = 5'b00100,
		S_RD_D = 5'b01000,
		S_EVAL = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers
	logic [SIDE_W-1:0]            side_q;
	logic [ilm_pkg::THRESH_W-1:0] thresh_four_q;
	logic [ilm_pkg::THRESH_W-1:0] thresh_eight_q;

	// Running totals
	logic signed [ilm_pkg::ENERGY_W-1:0] energy_q;
	logic signed [ilm_pkg::MAG_W-1:0]    mag_q;

	// Item held while it works through the memory
	logic                          action_q;
	logic                          spin_down_q;
	logic [ilm_pkg::UNIFORM_W-1:0] uniform_q;
	logic                          err_q;
	logic [ROW_W-1:0]              row_q, up_row_q, dn_row_q;
	logic [ROW_W-1:0]              col_q, lf_col_q, rt_col_q;

	// Bits gathered from the row reads
	logic [MAX_SIDE-1:0] row_buf_q;
	logic                site_q, left_q, right_q, up_q;

	// Output register
	logic                                out_valid_q;
	logic                                flipped_q, coord_error_q;
	logic signed [ilm_pkg::DELTA_W-1:0]  delta_q;
	logic signed [ilm_pkg::ENERGY_W-1:0] tot_energy_q;
	logic signed [ilm_pkg::MAG_W-1:0]    tot_mag_q;

	// Memory interface
	ilm_pkg::mem_ctrl_t  mem_ctrl;
	logic [ROW_W-1:0]    mem_rd_addr;
	logic [MAX_SIDE-1:0] mem_rd_row;
	logic [MAX_SIDE-1:0] new_row;

	// Accept-side decode
	logic             in_fire;
	logic             coord_bad;
	logic [ROW_W-1:0] row_in, col_in, side_m1;

	// Config decode
	logic [CLAMP_W-1:0] cfg_side_ext;
	logic [SIDE_W-1:0]  side_new;
	logic [SQ_W-1:0]    side_sq;
	logic               side_write;

	// Evaluate
	logic                               out_free;
	logic                               commit;
	logic                               dn_bit;
	logic [2:0]                         down_cnt;
	logic signed [ilm_pkg::DELTA_W-1:0] two_n;
	logic signed [ilm_pkg::DELTA_W-1:0] change;
	logic                               do_flip;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign commit   = (state_q == S_EVAL) && out_free;

	// Range check and wrapped neighbor coordinates
	assign coord_bad = (CMP_W'(row) >= CMP_W'(side_q)) || (CMP_W'(col) >= CMP_W'(side_q));
	assign row_in    = ROW_W'(row);
	assign col_in    = ROW_W'(col);
	assign side_m1   = ROW_W'(side_q - SIDE_W'(1));

	// Clamp the side value and square it for the fresh totals
	assign side_write   = cfg_write && (cfg_index == ilm_pkg::REG_SIDE);
	assign cfg_side_ext = CLAMP_W'(cfg_data[ilm_pkg::SIDE_CFG_W-1:0]);
	always_comb begin
		if (cfg_side_ext < CLAMP_MIN) begin
			side_new = SIDE_W'(CLAMP_MIN);
		end else if (cfg_side_ext > CLAMP_MAX) begin
			side_new = SIDE_W'(CLAMP_MAX);
		end else begin
			side_new = SIDE_W'(cfg_side_ext);
		end
	end
	assign side_sq = SQ_W'(side_new) * SQ_W'(side_new);

	// Energy change from the four neighbors: 2*s*N with N = 4 - 2*(downs)
	assign dn_bit   = mem_rd_row[col_q];
	assign down_cnt = 3'(up_q) + 3'(dn_bit) + 3'(left_q) + 3'(right_q);
	assign two_n    = $signed(ilm_pkg::DELTA_W'(8) - {down_cnt, 2'b00});
	assign change   = site_q ? -two_n : two_n;

	always_comb begin
		if (action_q == ilm_pkg::ACT_FLIP) begin
			if (change[ilm_pkg::DELTA_W-1] || (change == '0)) begin
				do_flip = 1'b1;
			end else if (change == DELTA_FOUR) begin
				do_flip = uniform_q < thresh_four_q;
			end else if (change == DELTA_EIGHT) begin
				do_flip = uniform_q < thresh_eight_q;
			end else begin
				do_flip = 1'b0;
			end
		end else begin
			do_flip = site_q != spin_down_q;
		end
	end

	always_comb begin
		new_row        = row_buf_q;
		new_row[col_q] = ~site_q;
	end

	// Sequencer: center, up and down rows through the one read port
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = coord_bad ? S_EVAL : S_RD_C;
				end
			end
			S_RD_C: state_d = S_RD_U;
			S_RD_U: state_d = S_RD_D;
			S_RD_D: state_d = S_EVAL;
			S_EVAL: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_ctrl.rd_en = 1'b0;
		mem_rd_addr    = row_q;
		case (state_q)
			S_RD_C: begin
				mem_ctrl.rd_en = 1'b1;
				mem_rd_addr    = row_q;
			end
			S_RD_U: begin
				mem_ctrl.rd_en = 1'b1;
				mem_rd_addr    = up_row_q;
			end
			S_RD_D: begin
				mem_ctrl.rd_en = 1'b1;
				mem_rd_addr    = dn_row_q;
			end
			default: mem_ctrl.rd_en = 1'b0;
		endcase
		mem_ctrl.wr_en = commit && !err_q && do_flip;
		mem_ctrl.clear = side_write;
	end

	ilm_lattice_mem #(
		.MAX_SIDE (MAX_SIDE)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mem_ctrl),
		.rd_addr (mem_rd_addr),
		.wr_addr (row_q),
		.wr_row  (new_row),
		.rd_row  (mem_rd_row)
	);

	// Control state, configuration and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			side_q         <= SIDE_RST;
			thresh_four_q  <= '0;
			thresh_eight_q <= '0;
			energy_q       <= $signed(ENERGY_RST);
			mag_q          <= $signed(MAG_RST);
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					ilm_pkg::REG_SIDE: begin
						side_q   <= side_new;
						energy_q <= $signed(ilm_pkg::ENERGY_W'(0)
							- ilm_pkg::ENERGY_W'({side_sq, 1'b0}));
						mag_q    <= $signed(ilm_pkg::MAG_W'(side_sq));
					end
					ilm_pkg::REG_THRESH_FOUR:  thresh_four_q  <= cfg_data;
					ilm_pkg::REG_THRESH_EIGHT: thresh_eight_q <= cfg_data;
					default: ;
				endcase
			end else if (mem_ctrl.wr_en) begin
				energy_q <= energy_q + ilm_pkg::ENERGY_W'(change);
				mag_q    <= site_q ? mag_q + ilm_pkg::MAG_W'(2) : mag_q - ilm_pkg::MAG_W'(2);
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture and row data
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q    <= action;
			spin_down_q <= spin_down;
			uniform_q   <= uniform;
			err_q       <= coord_bad;
			row_q       <= row_in;
			col_q       <= col_in;
			up_row_q    <= (row_in == side_m1) ? '0 : ROW_W'(row_in + ROW_W'(1));
			dn_row_q    <= (row_in == '0) ? side_m1 : ROW_W'(row_in - ROW_W'(1));
			rt_col_q    <= (col_in == side_m1) ? '0 : ROW_W'(col_in + ROW_W'(1));
			lf_col_q    <= (col_in == '0) ? side_m1 : ROW_W'(col_in - ROW_W'(1));
		end
		// center row arrives while the up row is being read
		if (state_q == S_RD_U) begin
			row_buf_q <= mem_rd_row;
			site_q    <= mem_rd_row[col_q];
			left_q    <= mem_rd_row[lf_col_q];
			right_q   <= mem_rd_row[rt_col_q];
		end
		if (state_q == S_RD_D) begin
			up_q <= mem_rd_row[col_q];
		end
	end

	// Result register; totals reflect this item's own update
	always_ff @(posedge clk) begin
		if (commit) begin
			coord_error_q <= err_q;
			if (err_q) begin
				flipped_q    <= 1'b0;
				delta_q      <= '0;
				tot_energy_q <= energy_q;
				tot_mag_q    <= mag_q;
			end else begin
				flipped_q <= (action_q == ilm_pkg::ACT_FLIP) && do_flip;
				delta_q   <= (action_q == ilm_pkg::ACT_FLIP) ? change : '0;
				if (do_flip) begin
					tot_energy_q <= energy_q + ilm_pkg::ENERGY_W'(change);
					tot_mag_q    <= site_q ? mag_q + ilm_pkg::MAG_W'(2)
						: mag_q - ilm_pkg::MAG_W'(2);
				end else begin
					tot_energy_q <= energy_q;
					tot_mag_q    <= mag_q;
				end
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign flipped             = flipped_q;
	assign coord_error         = coord_error_q;
	assign energy_change       = delta_q;
	assign total_energy        = tot_energy_q;
	assign total_magnetization = tot_mag_q;

endmodule

// File: src/ilm_checker.sv
// Port-level checks for the Ising lattice block, bound to its top level.
// Depends on ilm_pkg and ising_lattice_metropolis_assert.svh.
`timescale 1ns / 1ps
`include "ising_lattice_metropolis_assert.svh"

module ilm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                flipped,
	input logic                                coord_error,
	input logic signed [ilm_pkg::DELTA_W-1:0]  energy_change,
	input logic signed [ilm_pkg::ENERGY_W-1:0] total_energy,
	input logic signed [ilm_pkg::MAG_W-1:0]    total_magnetization
);

	logic [ilm_pkg::DELTA_W+ilm_pkg::ENERGY_W+ilm_pkg::MAG_W+1:0] out_beat;

	assign out_beat = {flipped, coord_error, energy_change, total_energy, total_magnetization};

	// Hold a stalled result beat
	`ILM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

	// One item at a time: drop ready right after a beat is taken
	`ILM_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// A rejected site reports no flip and no energy change
	`ILM_ASSERT_IMP(a_err_quiet, out_valid && coord_error, !flipped && (energy_change == '0))

	// An energy decrease is always accepted
	`ILM_ASSERT_IMP(a_downhill_flips, out_valid && energy_change[ilm_pkg::DELTA_W-1], flipped && !coord_error)

endmodule

bind ising_lattice_metropolis ilm_checker u_ilm_checker (.*);

// File: dv/tb_ising_lattice_metropolis.sv
// Self-checking testbench for ising_lattice_metropolis: a directed table, then random phases.
// Keeps its own lattice, energy and magnetization to predict every result; needs ilm_pkg only.
`timescale 1ns / 1ps

module tb_ising_lattice_metropolis;

	import ilm_pkg::*;

	localparam int CLK_PERIOD = 2;
	localparam int RESET_CYCLES = 7;
	localparam int RUN_LIMIT_NS = 1_000_000;
	// Extra cycles to let the block settle once no result is pending.
	localparam int SETTLE_CYCLES = 8;
	localparam int LATTICE_MAX = DEFAULT_MAX_SIDE;
	localparam int COORD_TOP = (1 << COORD_W) - 1;
	localparam logic ACT_WRITE = 1'b0;
	// Index with no register behind it; writes to it must leave everything alone.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic                        flipped;
		logic                        coord_error;
		logic signed [DELTA_W-1:0]   delta;
		logic signed [ENERGY_W-1:0]  energy;
		logic signed [MAG_W-1:0]     magnet;
	} lattice_result_t;

	// One row of the directed table: a register write or a beat, with an optional
	// hand-written result that replaces the predicted one.
	typedef struct {
		bit                     is_cfg;
		logic [CFG_IDX_W-1:0]   cfg_idx;
		logic [CFG_DATA_W-1:0]  cfg_val;
		logic                   act;
		logic [COORD_W-1:0]     r;
		logic [COORD_W-1:0]     c;
		logic                   dn;
		logic [UNIFORM_W-1:0]   uni;
		bit                     typed;
		lattice_result_t        res;
	} stim_row_t;

	typedef struct {
		logic [SIDE_CFG_W-1:0]  side;
		logic [THRESH_W-1:0]    t4;
		logic [THRESH_W-1:0]    t8;
		int                     count;
		int                     snd_pct;
		int                     rcv_pct;
	} phase_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_write;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	logic                         action;
	logic [COORD_W-1:0]           row;
	logic [COORD_W-1:0]           col;
	logic                         spin_down;
	logic [UNIFORM_W-1:0]         uniform;
	logic                         out_valid;
	logic                         out_ready;
	logic                         flipped;
	logic                         coord_error;
	logic signed [DELTA_W-1:0]    energy_change;
	logic signed [ENERGY_W-1:0]   total_energy;
	logic signed [MAG_W-1:0]      total_magnetization;

	ising_lattice_metropolis DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write           (cfg_write),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.action              (action),
		.row                 (row),
		.col                 (col),
		.spin_down           (spin_down),
		.uniform             (uniform),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.flipped             (flipped),
		.coord_error         (coord_error),
		.energy_change       (energy_change),
		.total_energy        (total_energy),
		.total_magnetization (total_magnetization)
	);

	// Lattice model: one bit per site, 1 = spin down, indexed row * LATTICE_MAX + col.
	logic            lattice_dn [LATTICE_MAX * LATTICE_MAX];
	int              side_n;
	logic [15:0]     thresh_four;
	logic [15:0]     thresh_eight;
	int              energy_sum;
	int              magnet_sum;

	lattice_result_t pending_results [$];
	lattice_result_t want;
	int              snd_idle_pct;
	int              rcv_idle_pct;
	int              mismatches;
	int              beats_sent;
	int              flips_taken;
	int              spin_writes;
	int              coord_errs;
	int              side_settings;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// All spins up: every bond aligned, so energy is -2 per site and magnetization +1 per site.
	function automatic void clear_lattice_model();
		foreach (lattice_dn[i]) lattice_dn[i] = 1'b0;
		energy_sum = -2 * side_n * side_n;
		magnet_sum = side_n * side_n;
	endfunction

	function automatic int spin_of(int r, int c);
		return lattice_dn[r * LATTICE_MAX + c] ? -1 : 1;
	endfunction

	// Apply one beat to the lattice model and return the result the block should give.
	function automatic lattice_result_t predict_beat(input logic act,
		input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c, input logic dn,
		input logic [UNIFORM_W-1:0] uni);
		lattice_result_t res;
		int ri, ci, n, idx, s, nsum, change;
		logic take;
		ri = int'(r);
		ci = int'(c);
		n = side_n;
		res.flipped = 1'b0;
		res.coord_error = 1'b0;
		res.delta = '0;
		if (ri >= n || ci >= n) begin
			res.coord_error = 1'b1;
			coord_errs++;
		end else begin
			idx = ri * LATTICE_MAX + ci;
			s = lattice_dn[idx] ? -1 : 1;
			// Wrapped neighbours; on side two the same site is counted from both directions.
			nsum = spin_of((ri + 1) % n, ci) + spin_of((ri + n - 1) % n, ci)
				+ spin_of(ri, (ci + 1) % n) + spin_of(ri, (ci + n - 1) % n);
			change = 2 * s * nsum;
			if (act == ACT_FLIP) begin
				res.delta = change[DELTA_W-1:0];
				if (change <= 0)
					take = 1'b1;
				else if (change == 4)
					take = uni < thresh_four;
				else if (change == 8)
					take = uni < thresh_eight;
				else
					take = 1'b0;
				res.flipped = take;
				if (take)
					flips_taken++;
			end else begin
				// A write only moves the totals when it really changes the spin.
				take = (lattice_dn[idx] != dn);
				spin_writes++;
			end
			if (take) begin
				lattice_dn[idx] = ~lattice_dn[idx];
				energy_sum += change;
				magnet_sum -= 2 * s;
			end
		end
		res.energy = energy_sum[ENERGY_W-1:0];
		res.magnet = magnet_sum[MAG_W-1:0];
		return res;
	endfunction

	function automatic stim_row_t item_row(input logic act, input int r, input int c,
		input logic dn, input int uni);
		stim_row_t t;
		t.is_cfg = 1'b0;
		t.cfg_idx = '0;
		t.cfg_val = '0;
		t.act = act;
		t.r = COORD_W'(r);
		t.c = COORD_W'(c);
		t.dn = dn;
		t.uni = UNIFORM_W'(uni);
		t.typed = 1'b0;
		return t;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
		stim_row_t t;
		t = item_row(ACT_WRITE, 0, 0, 1'b0, 0);
		t.is_cfg = 1'b1;
		t.cfg_idx = idx;
		t.cfg_val = CFG_DATA_W'(val);
		return t;
	endfunction

	function automatic stim_row_t with_result(input stim_row_t t, input logic f,
		input logic e, input int de, input int en, input int mg);
		t.typed = 1'b1;
		t.res.flipped = f;
		t.res.coord_error = e;
		t.res.delta = de[DELTA_W-1:0];
		t.res.energy = en[ENERGY_W-1:0];
		t.res.magnet = mg[MAG_W-1:0];
		return t;
	endfunction

	function automatic phase_t phase_row(input int side, input int t4, input int t8,
		input int count, input int snd_pct, input int rcv_pct);
		phase_t p;
		p.side = SIDE_CFG_W'(side);
		p.t4 = THRESH_W'(t4);
		p.t8 = THRESH_W'(t8);
		p.count = count;
		p.snd_pct = snd_pct;
		p.rcv_pct = rcv_pct;
		return p;
	endfunction

	// Mostly in range, a good share near the wrap seam, a few past the side in use.
	function automatic logic [COORD_W-1:0] pick_coord();
		int roll;
		roll = int'($urandom_range(99));
		if (roll < 6 && side_n < LATTICE_MAX)
			return COORD_W'($urandom_range(COORD_TOP, side_n));
		if (roll < 50 && side_n > 8)
			return COORD_W'((int'($urandom_range(7)) + side_n - 4) % side_n);
		return COORD_W'($urandom_range(side_n - 1));
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] exp_val,
		input logic signed [31:0] got_val);
		if (got_val !== exp_val) begin
			$display("t=%0d ns: %s mismatch, expected %0d, actual %0d",
				$time, name, exp_val, got_val);
			mismatches++;
		end
	endtask

	// Write one register and mirror it in the model. Call only while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int v;
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
		REG_SIDE: begin
			// Clamp into 2..LATTICE_MAX; a side write also resets the lattice to all up.
			v = int'(val[SIDE_CFG_W-1:0]);
			side_n = (v < 2) ? 2 : (v > LATTICE_MAX) ? LATTICE_MAX : v;
			clear_lattice_model();
			side_settings++;
		end
		REG_THRESH_FOUR: thresh_four = val[THRESH_W-1:0];
		REG_THRESH_EIGHT: thresh_eight = val[THRESH_W-1:0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	// Present one beat, idling first at the sender's rate; return at the accepting edge.
	task automatic send_item(input logic act, input logic [COORD_W-1:0] r,
		input logic [COORD_W-1:0] c, input logic dn, input logic [UNIFORM_W-1:0] uni);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		row <= r;
		col <= c;
		spin_down <= dn;
		uniform <= uni;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid, wait for every pending result, then let the pipeline settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: check each accepted beat against the oldest prediction, then pick
	// the next cycle's ready at the receiver's idle rate.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("t=%0d ns: unexpected result, actual energy %0d magnetization %0d",
					$time, total_energy, total_magnetization);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("flipped", want.flipped, flipped);
				check_field("coord_error", want.coord_error, coord_error);
				check_field("energy_change", want.delta, energy_change);
				check_field("total_energy", want.energy, total_energy);
				check_field("total_magnetization", want.magnet, total_magnetization);
			end
		end
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout with %0d results still pending", pending_results.size());
		$display("tb_ising_lattice_metropolis NOT OK");
		$finish;
	end

	initial begin
		lattice_result_t predicted;
		stim_row_t       dir_rows [$];
		phase_t          phases [$];
		logic            act_r;
		logic            dn_r;
		logic [COORD_W-1:0]   r_r;
		logic [COORD_W-1:0]   c_r;
		logic [UNIFORM_W-1:0] uni_r;

		// Hold every input at a known value through reset.
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_WRITE;
		row = '0;
		col = '0;
		spin_down = 1'b0;
		uniform = '0;
		out_ready = 1'b0;
		mismatches = 0;
		beats_sent = 0;
		flips_taken = 0;
		spin_writes = 0;
		coord_errs = 0;
		side_settings = 0;
		snd_idle_pct = 18;
		rcv_idle_pct = 66;

		// Model after reset: full side, both thresholds zero, all spins up.
		side_n = LATTICE_MAX;
		thresh_four = '0;
		thresh_eight = '0;
		clear_lattice_model();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Full lattice straight out of reset: all up, no threshold passes.
		dir_rows.push_back(with_result(item_row(ACT_FLIP, 0, 0, 1'b0, 0),
			1'b0, 1'b0, 8, -32768, 16384));
		dir_rows.push_back(item_row(ACT_WRITE, COORD_TOP, COORD_TOP, 1'b1, 0));
		dir_rows.push_back(item_row(ACT_FLIP, COORD_TOP, 0, 1'b0, 16'hFFFF));
		// Side zero clamps to two; coordinates past it are flagged and ignored.
		dir_rows.push_back(cfg_row(REG_SIDE, 0));
		dir_rows.push_back(with_result(item_row(ACT_FLIP, 2, 0, 1'b0, 0),
			1'b0, 1'b1, 0, -8, 4));
		dir_rows.push_back(with_result(item_row(ACT_FLIP, 0, COORD_TOP, 1'b1, 16'hFFFF),
			1'b0, 1'b1, 0, -8, 4));
		// Side two: each neighbour is seen twice.
		dir_rows.push_back(item_row(ACT_WRITE, 0, 0, 1'b1, 16'hFFFF));
		dir_rows.push_back(item_row(ACT_FLIP, 1, 1, 1'b0, 0));
		dir_rows.push_back(item_row(ACT_FLIP, 0, 0, 1'b1, 16'h1234));
		// Write that leaves the spin as it was.
		dir_rows.push_back(item_row(ACT_WRITE, 1, 0, 1'b0, 16'h5555));
		// Threshold extremes, an index with no register, then side three.
		dir_rows.push_back(cfg_row(REG_THRESH_FOUR, 16'hFFFF));
		dir_rows.push_back(cfg_row(REG_THRESH_EIGHT, 16'h8000));
		dir_rows.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
		dir_rows.push_back(cfg_row(REG_SIDE, 3));
		dir_rows.push_back(with_result(item_row(ACT_FLIP, 1, 1, 1'b0, 16'hFFFF),
			1'b0, 1'b0, 8, -18, 9));
		dir_rows.push_back(item_row(ACT_FLIP, 1, 1, 1'b0, 16'h7FFF));
		dir_rows.push_back(item_row(ACT_FLIP, 0, 1, 1'b0, 16'hFFFF));
		dir_rows.push_back(item_row(ACT_FLIP, 0, 1, 1'b0, 16'hFFFE));
		dir_rows.push_back(item_row(ACT_FLIP, 0, 2, 1'b0, 0));
		// Zero energy change flips whatever the uniform draw.
		dir_rows.push_back(item_row(ACT_FLIP, 1, 2, 1'b0, 16'hFFFF));
		dir_rows.push_back(item_row(ACT_FLIP, 1, 1, 1'b1, 16'hFFFF));
		dir_rows.push_back(item_row(ACT_FLIP, 0, 1, 1'b0, 16'hFFFF));
		dir_rows.push_back(item_row(ACT_WRITE, 2, 2, 1'b1, 16'hAAAA));
		dir_rows.push_back(item_row(ACT_WRITE, 5, 1, 1'b1, 0));
		// Side 128 again: wrap across the far edge; a zero draw passes the eight threshold.
		dir_rows.push_back(cfg_row(REG_SIDE, LATTICE_MAX));
		dir_rows.push_back(with_result(item_row(ACT_FLIP, COORD_TOP, COORD_TOP, 1'b0, 0),
			1'b1, 1'b0, 8, -32760, 16382));
		dir_rows.push_back(item_row(ACT_WRITE, 0, COORD_TOP, 1'b1, 0));
		dir_rows.push_back(item_row(ACT_FLIP, 0, 0, 1'b0, 16'hFFFF));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain_results();
				write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
			end else begin
				predicted = predict_beat(dir_rows[i].act, dir_rows[i].r, dir_rows[i].c,
					dir_rows[i].dn, dir_rows[i].uni);
				pending_results.push_back(dir_rows[i].typed ? dir_rows[i].res : predicted);
				beats_sent++;
				send_item(dir_rows[i].act, dir_rows[i].r, dir_rows[i].c, dir_rows[i].dn,
					dir_rows[i].uni);
			end
		end

		// Random phases: slow receiver, then slow sender, then full rate.
		phases.push_back(phase_row(5, $urandom_range(65535), $urandom_range(65535), 150, 18, 66));
		phases.push_back(phase_row(1, 16'hFFFF, 16'h0000, 80, 18, 66));
		phases.push_back(phase_row(16, 16'h8000, 16'h4000, 150, 66, 18));
		phases.push_back(phase_row(255, $urandom_range(65535), $urandom_range(65535), 100, 66, 18));
		phases.push_back(phase_row(3, 16'h0000, 16'hFFFF, 80, 0, 0));
		phases.push_back(phase_row(9, $urandom_range(65535), $urandom_range(65535), 190, 0, 0));

		foreach (phases[p]) begin
			drain_results();
			write_reg(REG_SIDE, CFG_DATA_W'(phases[p].side));
			write_reg(REG_THRESH_FOUR, phases[p].t4);
			write_reg(REG_THRESH_EIGHT, phases[p].t8);
			snd_idle_pct = phases[p].snd_pct;
			rcv_idle_pct = phases[p].rcv_pct;
			for (int k = 0; k < phases[p].count; k++) begin
				act_r = ($urandom_range(99) < 12) ? ACT_WRITE : ACT_FLIP;
				r_r = pick_coord();
				c_r = pick_coord();
				dn_r = 1'($urandom_range(1));
				// A quarter of draws land right on or next to a threshold.
				if ($urandom_range(3) == 0)
					uni_r = UNIFORM_W'(int'($urandom_range(1) ? thresh_four : thresh_eight)
						+ int'($urandom_range(2)) - 1);
				else
					uni_r = UNIFORM_W'($urandom);
				pending_results.push_back(predict_beat(act_r, r_r, c_r, dn_r, uni_r));
				beats_sent++;
				send_item(act_r, r_r, c_r, dn_r, uni_r);
			end
		end
		drain_results();

		$display("Sent %0d beats over %0d side settings: %0d flips accepted, %0d spin writes,",
			beats_sent, side_settings, flips_taken, spin_writes);
		$display("%0d coordinate errors, %0d mismatches", coord_errs, mismatches);
		if (mismatches == 0) begin
			$display("tb_ising_lattice_metropolis OK");
		end else begin
			$display("tb_ising_lattice_metropolis NOT OK");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/ilm_pkg.sv
src/ilm_lattice_mem.sv
src/ising_lattice_metropolis.sv
src/ilm_checker.sv
dv/tb_ising_lattice_metropolis.sv
